/* sv/fpc_pkg.sv */
// Shared types, widths and helpers for the frustum point cull block.
// No dependencies; used by frustum_point_cull.
package fpc_pkg;

   // Internal word width of matrix elements and point coordinates
   localparam int WORD_W  = 32;
   // Width of the input fields as they arrive on the ports
   localparam int FIELD_W = 32;
   // Fraction bits of the Q16.16 format (d term is scaled by one)
   localparam int FRAC_W  = 16;
   // Exact element * coordinate product
   localparam int PROD_W  = 2 * WORD_W;
   // d term: element times 1.0 in Q16.16
   localparam int DTERM_W = WORD_W + FRAC_W;
   // Row dot product: three products plus the d term
   localparam int DOT_W   = PROD_W + 2;
   // Plane value: row 3 plus or minus another row
   localparam int PLANE_W = DOT_W + 1;

   localparam int NUM_PLANES = 6;

   // Word kind on the request channel
   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TEST = 1'b1
   } kind_type;

   typedef logic signed [WORD_W-1:0] word_type;

   // Sign-extend a port field, then wrap it to the internal word width
   function automatic word_type to_word(input logic [FIELD_W-1:0] field);
      logic signed [FIELD_W+WORD_W-1:0] ext;
      ext = (FIELD_W + WORD_W)'($signed(field));
      return ext[WORD_W-1:0];
   endfunction

endpackage

/* sv/frustum_point_cull.sv */
// Frustum point cull: stores a 4x4 projection-view matrix and tests points
// against the six clip planes taken from it. Depends on fpc_pkg.
//
// Usage:
//   Request channel (req_*): valid/ready. A word with req_kind = load writes
//   matrix element [req_column][req_row] with req_element_value (Q16.16);
//   it gives no response. A word with req_kind = test brings a Q16.16 point
//   (req_point_x/y/z) and gives exactly one response word.
//   Response channel (rsp_*): valid/ready. rsp_inside_res is 1 when the
//   point lies on or inside all six planes; rsp_failed_planes has one bit
//   per plane (left, right, far, back, up, down) set when outside.
//   Throughput: one word per cycle while req_ready stays high, loads and tests mixed freely.
//   A test passes through the input register at the accepting edge, then
//   the product register (12 parallel 32x32 multipliers), the row dot
//   register and the response register.
//   Loads take effect in order: a test sees every load accepted before it.
//   Reset clears the matrix to zero and empties the pipeline.
//   When the receiver stalls, bubbles in the pipeline fill first; req_ready
//   drops only once every stage holds a word.
module frustum_point_cull (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [1:0]  req_column,
   input  logic [1:0]  req_row,
   input  logic signed [fpc_pkg::FIELD_W-1:0] req_element_value,
   input  logic signed [fpc_pkg::FIELD_W-1:0] req_point_x,
   input  logic signed [fpc_pkg::FIELD_W-1:0] req_point_y,
   input  logic signed [fpc_pkg::FIELD_W-1:0] req_point_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_inside_res,
   output logic [fpc_pkg::NUM_PLANES-1:0] rsp_failed_planes
);

   // Matrix store, indexed [column][row]
   fpc_pkg::word_type matrix_ff [4][4];

   // Stage 0: input register
   logic                s0_valid_ff, s0_valid_in;
   fpc_pkg::kind_type   s0_kind_ff;
   logic [1:0]          s0_col_ff, s0_row_ff;
   fpc_pkg::word_type   s0_value_ff;
   fpc_pkg::word_type   s0_point_ff [3];

   // Stage 1: products, [row][column], and d terms per row
   logic                                  s1_valid_ff, s1_valid_in;
   logic signed [fpc_pkg::PROD_W-1:0]     prod_ff [4][3];
   logic signed [fpc_pkg::PROD_W-1:0]     prod_in [4][3];
   logic signed [fpc_pkg::DTERM_W-1:0]    dterm_ff [4];
   logic signed [fpc_pkg::DTERM_W-1:0]    dterm_in [4];

   // Stage 2: row dot products
   logic                                  s2_valid_ff, s2_valid_in;
   logic signed [fpc_pkg::DOT_W-1:0]      dot_ff [4];
   logic signed [fpc_pkg::DOT_W-1:0]      dot_in [4];

   // Stage 3: response register
   logic                                  out_valid_ff, out_valid_in;
   logic [fpc_pkg::NUM_PLANES-1:0]        fail_ff, fail_in;

   logic s0_move, s1_move, s2_move, s0_is_load;
   logic signed [fpc_pkg::PLANE_W-1:0] plane [fpc_pkg::NUM_PLANES];

   // Pipeline advance: each stage moves when the next one is free or moving; a load in stage 0 always moves
   always_comb begin
      s0_is_load   = (s0_kind_ff == fpc_pkg::KIND_LOAD);
      s2_move      = s2_valid_ff && (!out_valid_ff || rsp_ready);
      s1_move      = s1_valid_ff && (!s2_valid_ff || s2_move);
      s0_move      = s0_valid_ff && (s0_is_load || !s1_valid_ff || s1_move);
      req_ready    = !s0_valid_ff || s0_move;

      s0_valid_in  = req_ready ? req_valid : s0_valid_ff;
      if (s0_move && !s0_is_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      if (s2_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Products of each row with the point, and the row's d term
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[j][c] = fpc_pkg::PROD_W'(matrix_ff[c][j]) *
                            fpc_pkg::PROD_W'(s0_point_ff[c]);
         end
         dterm_in[j] = {matrix_ff[3][j], {fpc_pkg::FRAC_W{1'b0}}};
      end
   end

   // Row dot products
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         dot_in[j] = fpc_pkg::DOT_W'(prod_ff[j][0]) + fpc_pkg::DOT_W'(prod_ff[j][1]) +
                     fpc_pkg::DOT_W'(prod_ff[j][2]) + fpc_pkg::DOT_W'(dterm_ff[j]);
      end
   end

   // Planes: row 3 plus or minus rows 0, 2, 1; fail on a negative value
   always_comb begin
      plane[0] = fpc_pkg::PLANE_W'(dot_ff[3]) + fpc_pkg::PLANE_W'(dot_ff[0]); // left
      plane[1] = fpc_pkg::PLANE_W'(dot_ff[3]) - fpc_pkg::PLANE_W'(dot_ff[0]); // right
      plane[2] = fpc_pkg::PLANE_W'(dot_ff[3]) + fpc_pkg::PLANE_W'(dot_ff[2]); // far
      plane[3] = fpc_pkg::PLANE_W'(dot_ff[3]) - fpc_pkg::PLANE_W'(dot_ff[2]); // back
      plane[4] = fpc_pkg::PLANE_W'(dot_ff[3]) - fpc_pkg::PLANE_W'(dot_ff[1]); // up
      plane[5] = fpc_pkg::PLANE_W'(dot_ff[3]) + fpc_pkg::PLANE_W'(dot_ff[1]); // down
      for (int i = 0; i < fpc_pkg::NUM_PLANES; i++) begin
         fail_in[i] = plane[i][fpc_pkg::PLANE_W-1];
      end
   end

   // Control state and matrix store
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               matrix_ff[c][r] <= '0;
            end
         end
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         // load words write the store as they leave stage 0, in order
         if (s0_move && s0_is_load) begin
            matrix_ff[s0_col_ff][s0_row_ff] <= s0_value_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s0_kind_ff     <= fpc_pkg::kind_type'(req_kind);
         s0_col_ff      <= req_column;
         s0_row_ff      <= req_row;
         s0_value_ff    <= fpc_pkg::to_word(req_element_value);
         s0_point_ff[0] <= fpc_pkg::to_word(req_point_x);
         s0_point_ff[1] <= fpc_pkg::to_word(req_point_y);
         s0_point_ff[2] <= fpc_pkg::to_word(req_point_z);
      end
      if (s0_move && !s0_is_load) begin
         prod_ff  <= prod_in;
         dterm_ff <= dterm_in;
      end
      if (s1_move) begin
         dot_ff <= dot_in;
      end
      if (s2_move) begin
         fail_ff <= fail_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_failed_planes = fail_ff;
   assign rsp_inside_res    = (fail_ff == '0);

endmodule
